/* rtl/core/i2p_pkg.sv */
// Shared constants for the ICCID to SF_EUIMID / pseudo-UIMID block.
package i2p_pkg;

   localparam logic [31:0] SHA_H0 = 32'h67452301;
   localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
   localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
   localparam logic [31:0] SHA_H3 = 32'h10325476;
   localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

   localparam logic [31:0] SHA_K0 = 32'h5A827999;
   localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

   localparam int unsigned SHA_ROUNDS = 80;
   localparam int unsigned MSG_BITS   = 56;

   localparam logic [4:0] MIN_DIGITS = 5'd18;
   localparam logic [7:0] PUIMID_TAG = 8'h80;
   localparam logic [7:0] MEID_LEAD  = 8'hA0;
   localparam logic [7:0] MSG_PAD    = 8'h80;

endpackage

/* rtl/core/i2p_sha1_core.sv */
// Iterative SHA-1 unit for a single padded 7-byte block, one round per cycle.
module i2p_sha1_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] msg,
   output logic        done,
   output logic [31:0] digest4
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RUN  = 3'b010,
      CS_FIN  = 3'b100
   } core_state_type;

   localparam logic [6:0] LAST_ROUND = 7'(i2p_pkg::SHA_ROUNDS - 1);

   core_state_type state_ff, state_in;
   logic [6:0]     round_ff, round_in;
   logic [31:0]    a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]    a_in, b_in, c_in, d_in, e_in;
   logic [31:0]    w_ff [16];
   logic [31:0]    w_in [16];
   logic [31:0]    f_val, k_val, t_val, w_mix, w_new;

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = i2p_pkg::SHA_K0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = i2p_pkg::SHA_K1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = i2p_pkg::SHA_K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = i2p_pkg::SHA_K3;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
      w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_mix[30:0], w_mix[31]};
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      case (state_ff)
         CS_IDLE, CS_FIN: begin
            state_in = CS_IDLE;
            if (start) begin
               state_in = CS_RUN;
               round_in = '0;
               a_in     = i2p_pkg::SHA_H0;
               b_in     = i2p_pkg::SHA_H1;
               c_in     = i2p_pkg::SHA_H2;
               d_in     = i2p_pkg::SHA_H3;
               e_in     = i2p_pkg::SHA_H4;
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = '0;
               end
               w_in[0]  = msg[55:24];
               w_in[1]  = {msg[23:0], i2p_pkg::MSG_PAD};
               w_in[15] = 32'(i2p_pkg::MSG_BITS);
            end
         end
         CS_RUN: begin
            a_in     = t_val;
            b_in     = a_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            d_in     = c_ff;
            e_in     = d_ff;
            round_in = round_ff + 7'd1;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = w_new;
            if (round_ff == LAST_ROUND) begin
               state_in = CS_FIN;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      round_ff <= round_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   assign done    = (state_ff == CS_FIN);
   assign digest4 = e_ff + i2p_pkg::SHA_H4;

endmodule

/* rtl/core/iccid_to_euimid_puimid.sv */
// Top level: derives SF_EUIMID and the pseudo-UIMID from ICCID nibbles.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  iccid_digits, digit_count
//   rsp      out        rsp_valid / rsp_stall  valid_res, sf_euimid, puimid
//   csr      in         csr_write_enable       csr_write_data (meid_mode)
//
// Every hash runs on the shared SHA-1 round unit, which does one round per cycle
// and 80 rounds per hash; plain mode hashes once per item, MEID mode twice.
// A short ICCID skips the hashes. Reset is synchronous and clears the mode.
// The request side stalls while an item is in work or its result is not yet taken.
module iccid_to_euimid_puimid (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [55:0] req_iccid_digits,
   input  logic [4:0]  req_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [55:0] rsp_sf_euimid,
   output logic [31:0] rsp_puimid,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_HASH1 = 4'b0010,
      ST_HASH2 = 4'b0100,
      ST_OUT   = 4'b1000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic          meid_ff;
   logic          vres_ff, vres_in;
   logic [55:0]   sf_ff, sf_in;
   logic [31:0]   pu_ff, pu_in;
   logic          req_take;
   logic          core_start;
   logic [55:0]   core_msg;
   logic          core_done;
   logic [31:0]   digest4;
   logic [55:0]   sf_plain;
   logic [55:0]   sf_meid;

   assign req_take = req_valid && !req_stall;
   assign sf_plain = {req_iccid_digits[7:0],   req_iccid_digits[15:8],
                      req_iccid_digits[23:16], req_iccid_digits[31:24],
                      req_iccid_digits[39:32], req_iccid_digits[47:40],
                      req_iccid_digits[55:48]};
   assign sf_meid  = {i2p_pkg::MEID_LEAD, 16'h0000, digest4[7:0], digest4[15:8],
                      digest4[23:16], digest4[31:24]};

   always_comb begin
      state_in   = state_ff;
      vres_in    = vres_ff;
      sf_in      = sf_ff;
      pu_in      = pu_ff;
      core_start = 1'b0;
      core_msg   = sf_plain;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_digit_count < i2p_pkg::MIN_DIGITS) begin
                  vres_in  = 1'b0;
                  sf_in    = '0;
                  pu_in    = '0;
                  state_in = ST_OUT;
               end else begin
                  vres_in    = 1'b1;
                  sf_in      = sf_plain;
                  core_start = 1'b1;
                  state_in   = ST_HASH1;
               end
            end
         end
         ST_HASH1: begin
            if (core_done) begin
               if (meid_ff) begin
                  sf_in      = sf_meid;
                  core_msg   = sf_meid;
                  core_start = 1'b1;
                  state_in   = ST_HASH2;
               end else begin
                  pu_in    = {digest4[7:0], digest4[15:8], digest4[23:16],
                              i2p_pkg::PUIMID_TAG};
                  state_in = ST_OUT;
               end
            end
         end
         ST_HASH2: begin
            if (core_done) begin
               pu_in    = {i2p_pkg::PUIMID_TAG, digest4[23:0]};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         meid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            meid_ff <= csr_write_data;
         end
      end
      vres_ff <= vres_in;
      sf_ff   <= sf_in;
      pu_ff   <= pu_in;
   end

   i2p_sha1_core u_sha1 (
      .clock   (clock),
      .reset   (reset),
      .start   (core_start),
      .msg     (core_msg),
      .done    (core_done),
      .digest4 (digest4)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_valid_res = vres_ff;
   assign rsp_sf_euimid = sf_ff;
   assign rsp_puimid    = pu_ff;

endmodule

/* tb/iccid_to_euimid_puimid_test.sv */
// Self-checking testbench for the ICCID to SF_EUIMID / pseudo-UIMID block.
`timescale 1ns / 1ps

module iccid_to_euimid_puimid_test;

   localparam bit         MODE_PLAIN  = 1'b0;
   localparam bit         MODE_MEID   = 1'b1;
   localparam logic [4:0] FULL_LENGTH = 5'd18;
   localparam logic [7:0] ID_TAG      = 8'h80;
   localparam logic [7:0] MEID_PREFIX = 8'hA0;
   localparam int         MAX_WAIT    = 16;
   localparam int         NUM_PHASES  = 6;
   localparam int         PHASE_ITEMS = 92;
   localparam int         NUM_ROWS    = 20;

   typedef struct packed {
      logic        ok;
      logic [55:0] sf;
      logic [31:0] pu;
   } derivation_type;

   typedef struct packed {
      bit             meid;
      logic [55:0]    digits;
      logic [4:0]     count;
      bit             given;
      derivation_type want;
   } stim_row_type;

   localparam derivation_type NO_ID = '0;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [55:0] req_iccid_digits;
   logic [4:0]  req_digit_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_valid_res;
   logic [55:0] rsp_sf_euimid;
   logic [31:0] rsp_puimid;
   logic        csr_write_enable;
   logic        csr_write_data;

   derivation_type pending_ids[$];
   bit             meid_shadow;
   bit             sender_calm;
   bit             receiver_calm;
   int             mismatches;
   int             items_sent;
   int             short_items;
   int             meid_items;
   int             results_seen;
   int             mode_writes;

   stim_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{MODE_PLAIN, 56'h00000000000000, 5'd0,  1'b1, NO_ID},
      '{MODE_PLAIN, 56'hFFFFFFFFFFFFFF, 5'd17, 1'b1, NO_ID},
      '{MODE_PLAIN, 56'h89014103211118, 5'd17, 1'b1, NO_ID},
      '{MODE_PLAIN, 56'h89014103211118, 5'd1,  1'b1, NO_ID},
      '{MODE_PLAIN, 56'h00000000000000, 5'd18, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'hFFFFFFFFFFFFFF, 5'd18, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'h89014103211118, 5'd19, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'h0123456789ABCD, 5'd20, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'hFEDCBA98765432, 5'd31, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'h80000000000001, 5'd18, 1'b0, NO_ID},
      '{MODE_MEID,  56'h00000000000000, 5'd18, 1'b0, NO_ID},
      '{MODE_MEID,  56'hFFFFFFFFFFFFFF, 5'd31, 1'b0, NO_ID},
      '{MODE_MEID,  56'h89014103211118, 5'd19, 1'b0, NO_ID},
      '{MODE_MEID,  56'hFFFFFFFFFFFFFF, 5'd17, 1'b1, NO_ID},
      '{MODE_MEID,  56'h00000000000000, 5'd0,  1'b1, NO_ID},
      '{MODE_MEID,  56'hAAAAAAAAAAAAAA, 5'd22, 1'b0, NO_ID},
      '{MODE_MEID,  56'h55555555555555, 5'd20, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'hAAAAAAAAAAAAAA, 5'd18, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'h00000000000001, 5'd31, 1'b0, NO_ID},
      '{MODE_PLAIN, 56'h55555555555555, 5'd16, 1'b1, NO_ID}
   };

   iccid_to_euimid_puimid dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_iccid_digits (req_iccid_digits),
      .req_digit_count  (req_digit_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_sf_euimid    (rsp_sf_euimid),
      .rsp_puimid       (rsp_puimid),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // One padded block: seven message bytes, the 0x80 pad, zeros, bit length 56.
   function automatic logic [159:0] sha1_block56(input logic [55:0] msg);
      logic [511:0] blk;
      logic [31:0]  w [0:79];
      logic [31:0]  a, b, c, d, e, f, k, t;
      blk = {msg, 8'h80, 440'h0, 8'd56};
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = 32'h67452301;
      b = 32'hEFCDAB89;
      c = 32'h98BADCFE;
      d = 32'h10325476;
      e = 32'hC3D2E1F0;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      return {a + 32'h67452301, b + 32'hEFCDAB89, c + 32'h98BADCFE,
              d + 32'h10325476, e + 32'hC3D2E1F0};
   endfunction

   function automatic derivation_type derive_ids(input logic [55:0] digits,
                                                 input logic [4:0] count, input bit meid);
      derivation_type r;
      logic [159:0]   dg;
      logic [55:0]    sf;
      r = NO_ID;
      if (count >= FULL_LENGTH) begin
         for (int i = 0; i < 7; i++) sf[55 - 8 * i -: 8] = digits[8 * i +: 8];
         dg = sha1_block56(sf);
         if (meid == MODE_PLAIN) begin
            r.pu = {dg[7:0], dg[15:8], dg[23:16], ID_TAG};
         end else begin
            sf = {MEID_PREFIX, 8'h00, 8'h00, dg[7:0], dg[15:8], dg[23:16], dg[31:24]};
            dg = sha1_block56(sf);
            r.pu = {ID_TAG, dg[23:16], dg[15:8], dg[7:0]};
         end
         r.ok = 1'b1;
         r.sf = sf;
      end
      return r;
   endfunction

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [55:0] pick_digits();
      logic [55:0] v;
      v = 56'({$urandom(), $urandom()});
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2, 3, 4, 5: begin
            for (int n = 0; n < 14; n++) v[4 * n +: 4] = 4'($urandom_range(0, 9));
            if ($urandom_range(0, 1) == 1) v[55:48] = 8'h89;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic offer_item(input logic [55:0] digits, input logic [4:0] count,
                             input bit given, input derivation_type want);
      int gap;
      gap = draw_wait(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_iccid_digits <= digits;
      req_digit_count  <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_ids.push_back(given ? want : derive_ids(digits, count, meid_shadow));
      items_sent++;
      if (count < FULL_LENGTH) short_items++;
      else if (meid_shadow == MODE_MEID) meid_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_ids.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_mode(input bit m);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      meid_shadow = m;
      mode_writes++;
   endtask

   always @(posedge clock) begin : check_results
      derivation_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_ids.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
         end else begin
            head = pending_ids.pop_front();
            if (rsp_valid_res !== head.ok) begin
               $error("valid_res: expected %0b, got %0b", head.ok, rsp_valid_res);
               mismatches++;
            end
            if (rsp_sf_euimid !== head.sf) begin
               $error("sf_euimid: expected %014h, got %014h", head.sf, rsp_sf_euimid);
               mismatches++;
            end
            if (rsp_puimid !== head.pu) begin
               $error("puimid: expected %08h, got %08h", head.pu, rsp_puimid);
               mismatches++;
            end
         end
      end
   end

   initial begin : result_sink
      int hold;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         hold = draw_wait(receiver_calm);
         rsp_stall <= (hold != 0);
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (hold != 0) begin
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d results outstanding.", pending_ids.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      bit flip;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_iccid_digits = '0;
      req_digit_count  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      meid_shadow      = MODE_PLAIN;
      sender_calm      = 1'b0;
      receiver_calm    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_mode(MODE_PLAIN);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].meid != meid_shadow) set_mode(directed_rows[i].meid);
         offer_item(directed_rows[i].digits, directed_rows[i].count,
                    directed_rows[i].given, directed_rows[i].want);
      end

      flip = 1'($urandom_range(0, 1));
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_mode(1'(p % 2) ^ flip);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) begin
               sender_calm   = ($urandom_range(0, 3) == 0);
               receiver_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 59) == 0) drain_results();
            offer_item(pick_digits(),
                       ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 17))
                                                   : 5'($urandom_range(18, 31)),
                       1'b0, NO_ID);
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      $display("Sent %0d items (%0d short ICCIDs, %0d in MEID form) over %0d mode writes.",
               items_sent, short_items, meid_items, mode_writes);
      $display("Checked %0d results, %0d field mismatches.", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
